[rtl/assert_macros.svh]
// Assertion macros shared by the move controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[rtl/ddsm_pkg.sv]
// Shared types, codes and constants of the move controller.
`default_nettype none
package ddsm_pkg;

	localparam int CMD_W      = 3;
	localparam int AMOUNT_W   = 20;
	localparam int RADIUS_W   = 10;
	localparam int SPACING_W  = 12;
	localparam int IV_W       = 14;
	localparam int OUT_W      = 7;
	localparam int IN_TDATA_W = 24;
	localparam int OUT_TDATA_W = 8;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	// amount * 200000 needs 38 bits; 3143 * radius needs 22 bits
	localparam int FACTOR_W = 18;
	localparam int NUM_W    = AMOUNT_W + FACTOR_W;
	localparam int DEN_W    = 22;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int QDEPTH          = 2;

	localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FORWARD = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ROT_R   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ROT_L   = 3'd4;

	// register select is the word address bit
	localparam logic REG_RADIUS  = 1'b0;
	localparam logic REG_SPACING = 1'b1;

	localparam logic [RADIUS_W-1:0]  RADIUS_RST  = 10'd40;
	localparam logic [SPACING_W-1:0] SPACING_RST = 12'd200;

	localparam logic [IV_W-1:0] INTERVAL_START = 14'd10000;
	localparam logic [IV_W-1:0] INTERVAL_FLOOR = 14'd5000;
	localparam logic [IV_W-1:0] INTERVAL_DROP  = 14'd100;

	localparam logic [FACTOR_W-1:0] STRAIGHT_NUM = 18'd200000;
	localparam logic [11:0]         STRAIGHT_DEN = 12'd3143;
	localparam logic [2:0]          ROT_NUM      = 3'd5;
	localparam logic [11:0]         ROT_DEN      = 12'd9;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_MOVE,
		KIND_NOP
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic                straight;
		logic                left_fwd;
		logic                right_fwd;
		logic [AMOUNT_W-1:0] amount;
	} item_t;

endpackage
`default_nettype wire

[rtl/ddsm_front.sv]
// Front end: takes input beats and decodes them into queue items.
`default_nettype none
module ddsm_front (
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [ddsm_pkg::IN_TDATA_W-1:0] s_tdata,
	input  wire logic [ddsm_pkg::CMD_W-1:0]    s_tuser,
	input  wire logic                          q_full,
	output logic                               q_push,
	output ddsm_pkg::item_t                    q_item
);

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_item.amount    = s_tdata[ddsm_pkg::AMOUNT_W-1:0];
		q_item.kind      = ddsm_pkg::KIND_NOP;
		q_item.straight  = 1'b0;
		q_item.left_fwd  = 1'b0;
		q_item.right_fwd = 1'b0;
		unique case (s_tuser)
			ddsm_pkg::CMD_TICK: begin
				q_item.kind = ddsm_pkg::KIND_TICK;
			end
			ddsm_pkg::CMD_FORWARD: begin
				q_item.kind      = ddsm_pkg::KIND_MOVE;
				q_item.straight  = 1'b1;
				q_item.left_fwd  = 1'b1;
				q_item.right_fwd = 1'b1;
			end
			ddsm_pkg::CMD_REVERSE: begin
				q_item.kind     = ddsm_pkg::KIND_MOVE;
				q_item.straight = 1'b1;
			end
			ddsm_pkg::CMD_ROT_R: begin
				q_item.kind     = ddsm_pkg::KIND_MOVE;
				q_item.left_fwd = 1'b1;
			end
			ddsm_pkg::CMD_ROT_L: begin
				q_item.kind      = ddsm_pkg::KIND_MOVE;
				q_item.right_fwd = 1'b1;
			end
			default: begin
				q_item.kind = ddsm_pkg::KIND_NOP;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/ddsm_queue.sv]
// Short item queue between the front end and the move engine.
`default_nettype none
`include "assert_macros.svh"
module ddsm_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ddsm_pkg::item_t push_item,
	output logic                 full,
	input  wire logic            pop,
	output logic                 valid,
	output ddsm_pkg::item_t      head
);

	localparam int PTR_W = (ddsm_pkg::QDEPTH > 1) ? $clog2(ddsm_pkg::QDEPTH) : 1;
	localparam int CNT_W = $clog2(ddsm_pkg::QDEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ddsm_pkg::QDEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ddsm_pkg::QDEPTH);

	ddsm_pkg::item_t  mem_q [ddsm_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_FULL);
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_push_full, clk, arst_n, push && full)
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && !valid)
	`ASSERT_CLK(a_count_up, clk, arst_n, (push && !pop) |=> (count_q == $past(count_q) + 1'b1))

endmodule
`default_nettype wire

[rtl/ddsm_back.sv]
// Move engine: step count division, step timing and the result register.
`default_nettype none
`include "assert_macros.svh"
module ddsm_back #(
	parameter int COUNT_WIDTH = ddsm_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [ddsm_pkg::RADIUS_W-1:0]   wheel_radius,
	input  wire logic [ddsm_pkg::SPACING_W-1:0]  wheel_spacing,
	input  wire logic                            q_valid,
	input  wire ddsm_pkg::item_t                 q_item,
	output logic                                 q_pop,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [ddsm_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	localparam int NUM_W = ddsm_pkg::NUM_W;
	localparam int DEN_W = ddsm_pkg::DEN_W;
	localparam int IV_W  = ddsm_pkg::IV_W;
	localparam int CNT_W = $clog2(NUM_W);
	localparam int EXT_W = (NUM_W > COUNT_WIDTH) ? NUM_W : COUNT_WIDTH;
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);
	localparam logic [EXT_W-1:0] COUNT_MAX = EXT_W'({COUNT_WIDTH{1'b1}});

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	// control state
	logic [1:0]             state_q, state_nx;
	logic [CNT_W-1:0]       cnt_q;
	logic                   running_q, running_nx;
	logic                   ramp_q, ramp_nx;
	logic                   left_q, left_nx;
	logic                   right_q, right_nx;
	logic [COUNT_WIDTH-1:0] steps_q, steps_nx;
	logic [IV_W-1:0]        interval_q, interval_nx;
	logic [IV_W-1:0]        wait_q, wait_nx;
	logic                   out_valid_q;
	logic [ddsm_pkg::OUT_W-1:0] out_data_q;

	// datapath
	ddsm_pkg::item_t        mv_q;
	logic [NUM_W-1:0]       num_q;
	logic [DEN_W-1:0]       den_q;
	logic [DEN_W-1:0]       rem_q;

	logic                   out_free, out_wr;
	logic                   pulse, done, rej;
	logic [ddsm_pkg::RADIUS_W-1:0] radius_eff;
	logic [ddsm_pkg::FACTOR_W-1:0] factor;
	logic [DEN_W:0]         trial;
	logic                   ge;
	logic [EXT_W-1:0]       quo_ext, quo_sat;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = ddsm_pkg::OUT_TDATA_W'(out_data_q);

	assign radius_eff = (wheel_radius == '0) ? ddsm_pkg::RADIUS_W'(1) : wheel_radius;
	assign factor = mv_q.straight ? ddsm_pkg::STRAIGHT_NUM
		: ddsm_pkg::FACTOR_W'(wheel_spacing) * ddsm_pkg::FACTOR_W'(ddsm_pkg::ROT_NUM);

	// one quotient bit per cycle, dividend shifts out as quotient shifts in
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = (trial >= {1'b0, den_q});

	assign quo_ext = EXT_W'(num_q);
	assign quo_sat = (quo_ext > COUNT_MAX) ? COUNT_MAX : quo_ext;

	always_comb begin
		state_nx    = state_q;
		running_nx  = running_q;
		ramp_nx     = ramp_q;
		left_nx     = left_q;
		right_nx    = right_q;
		steps_nx    = steps_q;
		interval_nx = interval_q;
		wait_nx     = wait_q;
		pulse       = 1'b0;
		done        = 1'b0;
		rej         = 1'b0;
		out_wr      = 1'b0;
		q_pop       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && out_free) begin
					q_pop  = 1'b1;
					out_wr = 1'b1;
					unique case (q_item.kind)
						ddsm_pkg::KIND_TICK: begin
							if (running_q) begin
								if (wait_q == '0) begin
									if (steps_q == '0) begin
										running_nx = 1'b0;
										done       = 1'b1;
									end else begin
										pulse    = 1'b1;
										steps_nx = steps_q - 1'b1;
										wait_nx  = interval_q - 1'b1;
										if (ramp_q && interval_q > ddsm_pkg::INTERVAL_FLOOR) begin
											interval_nx = interval_q - ddsm_pkg::INTERVAL_DROP;
										end
									end
								end else begin
									wait_nx = wait_q - 1'b1;
								end
							end
						end
						ddsm_pkg::KIND_MOVE: begin
							if (running_q) begin
								rej = 1'b1;
							end else begin
								out_wr   = 1'b0;
								state_nx = ST_MUL;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_MUL: begin
				state_nx = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_nx = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_wr      = 1'b1;
					state_nx    = ST_IDLE;
					steps_nx    = COUNT_WIDTH'(quo_sat);
					left_nx     = mv_q.left_fwd;
					right_nx    = mv_q.right_fwd;
					ramp_nx     = mv_q.straight;
					interval_nx = ddsm_pkg::INTERVAL_START;
					wait_nx     = '0;
					running_nx  = (quo_sat != '0);
					done        = (quo_sat == '0);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			running_q   <= 1'b0;
			ramp_q      <= 1'b0;
			left_q      <= 1'b0;
			right_q     <= 1'b0;
			steps_q     <= '0;
			interval_q  <= ddsm_pkg::INTERVAL_START;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_nx;
			running_q  <= running_nx;
			ramp_q     <= ramp_nx;
			left_q     <= left_nx;
			right_q    <= right_nx;
			steps_q    <= steps_nx;
			interval_q <= interval_nx;
			wait_q     <= wait_nx;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (out_wr) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_pop && q_item.kind == ddsm_pkg::KIND_MOVE) begin
			mv_q <= q_item;
		end
		if (state_q == ST_MUL) begin
			num_q <= NUM_W'(mv_q.amount) * NUM_W'(factor);
			den_q <= DEN_W'(radius_eff) * DEN_W'(mv_q.straight ? ddsm_pkg::STRAIGHT_DEN
				: ddsm_pkg::ROT_DEN);
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
		end
		if (out_wr) begin
			// rejected, done, busy, power, right, left, step from the top bit down
			out_data_q <= {rej, done, running_nx, running_nx, right_nx, left_nx, pulse};
		end
	end

	`ASSERT_CLK(a_no_pop_busy, clk, arst_n, (state_q != ST_IDLE) |-> !q_pop)
	`ASSERT_CLK(a_div_count, clk, arst_n, (state_q == ST_DIV && cnt_q != DIV_LAST) |=> (state_q == ST_DIV && cnt_q == $past(cnt_q) + 1'b1))
	`ASSERT_CLK(a_interval_range, clk, arst_n, (interval_q >= ddsm_pkg::INTERVAL_FLOOR) && (interval_q <= ddsm_pkg::INTERVAL_START))
	`ASSERT_NEVER(a_rej_idle, clk, arst_n, out_wr && rej && !running_q)

endmodule
`default_nettype wire

[rtl/diff_drive_stepper_move_controller.sv]
// Top level of the two-wheel stepper cart move controller.
//
// Input stream (s_t*): one beat per item. s_tuser carries the command
// (tick, forward, reverse, rotate right, rotate left), s_tdata the amount.
// Output stream (m_t*): exactly one result beat per input beat, in order.
// Configuration: APB-style port, wheel_radius at 0x0, wheel_spacing at 0x4,
// pready tied high; write only while no beat is in flight.
// Path: a tick or ignored/rejected beat is written into the queue, then popped
// by the engine into the result register, which drives m_tvalid.
// An accepted move command goes through the pop, a multiply state, the
// one-bit-per-cycle restoring divider and a finish state.
// Throughput: one tick per cycle while the receiver keeps m_tready high; a move
// command ties up the engine for its whole division.
// Front end and engine are decoupled by a two-entry queue, so beats keep
// being accepted while the engine divides, until the queue fills.
// Receiver stall: the result register holds its beat; the engine waits,
// the queue fills and then s_tready drops. Nothing is lost.
// Reset (arst_n low): idle, no move, interval 10000, directions reverse,
// registers at radius 40 and spacing 200; queue and result register empty.
`default_nettype none
module diff_drive_stepper_move_controller #(
	parameter int COUNT_WIDTH = ddsm_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input beat
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [ddsm_pkg::IN_TDATA_W-1:0]   s_tdata,  // [19:0] amount
	input  wire logic [ddsm_pkg::CMD_W-1:0]        s_tuser,  // [2:0] command
	// result beat
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [0] step_pulse, [1] left_forward, [2] right_forward, [3] power_on,
	// [4] busy_res, [5] done_res, [6] rejected
	output logic [ddsm_pkg::OUT_TDATA_W-1:0]       m_tdata,
	// configuration
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [ddsm_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [ddsm_pkg::DATA_W-1:0]       pwdata,
	output logic [ddsm_pkg::DATA_W-1:0]            prdata,
	output logic                                   pready
);

	logic [ddsm_pkg::RADIUS_W-1:0]  radius_q;
	logic [ddsm_pkg::SPACING_W-1:0] spacing_q;
	logic                           cfg_wr;

	ddsm_pkg::item_t push_item;
	ddsm_pkg::item_t head_item;
	logic            q_push, q_full, q_valid, q_pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// word address bit picks the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= ddsm_pkg::RADIUS_RST;
			spacing_q <= ddsm_pkg::SPACING_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == ddsm_pkg::REG_RADIUS) begin
				radius_q <= pwdata[ddsm_pkg::RADIUS_W-1:0];
			end else begin
				spacing_q <= pwdata[ddsm_pkg::SPACING_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == ddsm_pkg::REG_SPACING)
		? ddsm_pkg::DATA_W'(spacing_q) : ddsm_pkg::DATA_W'(radius_q);

	ddsm_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	ddsm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (head_item)
	);

	ddsm_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.wheel_radius  (radius_q),
		.wheel_spacing (spacing_q),
		.q_valid       (q_valid),
		.q_item        (head_item),
		.q_pop         (q_pop),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata)
	);

endmodule
`default_nettype wire
